FILE: hw/rtl/fcte_pkg.sv
// Shared types, codes and defaults for the chain table engine.
package fcte_pkg;

    // Default table shape
    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int END_MARK_DEF    = 2047;

    // Field widths
    localparam int OP_W    = 2;
    localparam int BLK_W   = 10;
    localparam int ENTRY_W = 11;
    localparam int CNT_W   = 11;
    localparam int ST_W    = 2;

    // Operation codes
    localparam logic [OP_W-1:0] OP_SET   = 2'd0;
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd2;
    localparam logic [OP_W-1:0] OP_MAP   = 2'd3;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_NONE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FREE,
        S_SCAN,
        S_LINK,
        S_WALK,
        S_DONE
    } t_state;

endpackage

FILE: hw/rtl/fat_chain_table_engine_unit.sv
// Chain table engine: next-block table in one synchronous memory with a sequencer.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_op i_block i_value i_chain_index i_grow
//  out     | output    | o_out_valid / i_out_ready  | o_result_block o_first_block
//          |           |                            | o_freed_count o_status
//
//  Memory: the table memory has one read and one write port. Set entry writes its entry;
//  allocate scans for a free entry; free chain clears each entry along the chain; map walks
//  the links and, when growing, scans for free entries and writes links to them; the allocation
//  scan of one map resumes where the last one stopped.
//  Reset: a clearing pass zeroes every entry of the table; o_in_ready stays low meanwhile.
//  Stalls: a finished item sits in the output register; the next item is accepted meanwhile,
//  and it waits in its final state only while that register is still full.
module fat_chain_table_engine_unit
    import fcte_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int END_MARK    = END_MARK_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [OP_W-1:0]    i_op,
    input  logic [BLK_W-1:0]   i_block,
    input  logic [ENTRY_W-1:0] i_value,
    input  logic [BLK_W-1:0]   i_chain_index,
    input  logic               i_grow,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [BLK_W-1:0]   o_result_block,
    output logic [BLK_W-1:0]   o_first_block,
    output logic [CNT_W-1:0]   o_freed_count,
    output logic [ST_W-1:0]    o_status
);

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int FCNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [ADDR_W-1:0]  LAST_ADDR = ADDR_W'(TABLE_DEPTH - 1);
    localparam logic [ENTRY_W-1:0] END_VAL   = ENTRY_W'(END_MARK);

    // Table memory
    logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic [ADDR_W-1:0]  mem_raddr;
    logic [ENTRY_W-1:0] r_rdata_mem;
    logic               r_fwd_hit;
    logic [ENTRY_W-1:0] r_fwd_data;
    logic [ENTRY_W-1:0] rdata;

    // Sequencer registers
    t_state             r_state, n_state;
    logic [ADDR_W-1:0]  r_clr, n_clr;
    logic [OP_W-1:0]    r_op, n_op;
    logic [ADDR_W-1:0]  r_b, n_b;
    logic [ADDR_W-1:0]  r_scan, n_scan;
    logic [ADDR_W-1:0]  r_alloc_from, n_alloc_from;
    logic [BLK_W-1:0]   r_k, n_k;
    logic               r_grow, n_grow;
    logic               r_for_first, n_for_first;
    logic [FCNT_W-1:0]  r_count, n_count;
    logic [BLK_W-1:0]   r_res, n_res;
    logic [BLK_W-1:0]   r_fb, n_fb;
    logic [ST_W-1:0]    r_st, n_st;
    logic               r_out_valid;

    // Decodes
    logic              in_fire;
    logic              in_blk_ok;
    logic              e_zero;
    logic              e_end;
    logic              e_out;
    logic              scan_last;
    logic              k_last;
    logic [FCNT_W-1:0] cnt_inc;
    logic              free_stop;
    logic              out_free;
    logic              out_load;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign in_blk_ok  = 32'(i_block) < 32'(TABLE_DEPTH);
    assign e_zero     = (rdata == '0);
    assign e_end      = (rdata == END_VAL);
    assign e_out      = 32'(rdata) >= 32'(TABLE_DEPTH);
    assign scan_last  = (r_scan == LAST_ADDR);
    assign k_last     = (r_k == BLK_W'(1));
    assign cnt_inc    = r_count + FCNT_W'(1);
    assign free_stop  = (cnt_inc == FCNT_W'(TABLE_DEPTH)) || e_zero || e_end || e_out;
    assign out_free   = !r_out_valid || i_out_ready;
    assign out_load   = (r_state == S_DONE) && out_free;

    // Registered read; forward a write to the entry being read
    assign rdata = r_fwd_hit ? r_fwd_data : r_rdata_mem;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata_mem <= mem[mem_raddr];
        r_fwd_data  <= mem_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else begin
            r_fwd_hit <= mem_we && (mem_waddr == mem_raddr);
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == LAST_ADDR) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (in_fire) begin
                    case (i_op)
                        OP_SET:   n_state = S_DONE;
                        OP_ALLOC: n_state = S_SCAN;
                        OP_FREE: begin
                            n_state = (i_block == '0 || !in_blk_ok) ? S_DONE : S_FREE;
                        end
                        default: begin
                            if (i_block == '0) begin
                                n_state = i_grow ? S_SCAN : S_DONE;
                            end else if (!in_blk_ok || i_chain_index == '0) begin
                                n_state = S_DONE;
                            end else begin
                                n_state = S_WALK;
                            end
                        end
                    endcase
                end
            end
            S_FREE: begin
                if (free_stop) n_state = S_DONE;
            end
            S_SCAN: begin
                if (e_zero) begin
                    if (r_op == OP_ALLOC) begin
                        n_state = S_DONE;
                    end else if (r_for_first) begin
                        n_state = (r_k == '0) ? S_DONE : S_WALK;
                    end else begin
                        n_state = S_LINK;
                    end
                end else if (scan_last) begin
                    n_state = S_DONE;
                end
            end
            S_LINK: begin
                n_state = k_last ? S_DONE : S_WALK;
            end
            S_WALK: begin
                if (e_end) begin
                    n_state = r_grow ? S_SCAN : S_DONE;
                end else if (e_out || k_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Memory controls and working values
    always_comb begin
        mem_we       = 1'b0;
        mem_waddr    = r_b;
        mem_wdata    = '0;
        mem_raddr    = '0;
        n_clr        = r_clr;
        n_op         = r_op;
        n_b          = r_b;
        n_scan       = r_scan;
        n_alloc_from = r_alloc_from;
        n_k          = r_k;
        n_grow       = r_grow;
        n_for_first  = r_for_first;
        n_count      = r_count;
        n_res        = r_res;
        n_fb         = r_fb;
        n_st         = r_st;
        case (r_state)
            S_CLEAR: begin
                // Zero one entry a cycle
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                n_clr     = r_clr + ADDR_W'(1);
            end
            S_IDLE: begin
                if (in_fire) begin
                    n_op         = i_op;
                    n_k          = i_chain_index;
                    n_grow       = i_grow;
                    n_count      = '0;
                    n_res        = '0;
                    n_fb         = '0;
                    n_st         = ST_OK;
                    n_b          = ADDR_W'(i_block);
                    n_scan       = '0;
                    n_alloc_from = '0;
                    n_for_first  = 1'b0;
                    case (i_op)
                        OP_SET: begin
                            mem_we    = in_blk_ok;
                            mem_waddr = ADDR_W'(i_block);
                            mem_wdata = i_value;
                        end
                        OP_ALLOC: begin
                            mem_raddr = '0;
                        end
                        OP_FREE: begin
                            mem_raddr = ADDR_W'(i_block);
                        end
                        default: begin
                            n_fb = i_block;
                            if (i_block == '0) begin
                                if (i_grow) begin
                                    n_for_first = 1'b1;
                                end else begin
                                    n_st = ST_NONE;
                                end
                            end else if (!in_blk_ok) begin
                                n_st = ST_NONE;
                            end else if (i_chain_index == '0) begin
                                n_res = i_block;
                            end else begin
                                mem_raddr = ADDR_W'(i_block);
                            end
                        end
                    endcase
                end
            end
            S_FREE: begin
                // Clear this entry and follow its link
                mem_we    = 1'b1;
                mem_waddr = r_b;
                n_count   = cnt_inc;
                if (!free_stop) begin
                    mem_raddr = ADDR_W'(rdata);
                    n_b       = ADDR_W'(rdata);
                end
            end
            S_SCAN: begin
                if (e_zero) begin
                    // Claim the free entry as a chain end
                    mem_we       = 1'b1;
                    mem_waddr    = r_scan;
                    mem_wdata    = END_VAL;
                    n_alloc_from = r_scan;
                    if (r_op == OP_ALLOC) begin
                        n_res = BLK_W'(r_scan);
                    end else if (r_for_first) begin
                        n_fb        = BLK_W'(r_scan);
                        n_b         = r_scan;
                        n_for_first = 1'b0;
                        if (r_k == '0) begin
                            n_res = BLK_W'(r_scan);
                        end else begin
                            mem_raddr = r_scan;
                        end
                    end
                end else if (scan_last) begin
                    n_st  = ST_FULL;
                    n_res = '0;
                    if (r_for_first) n_fb = '0;
                end else begin
                    mem_raddr = r_scan + ADDR_W'(1);
                    n_scan    = r_scan + ADDR_W'(1);
                end
            end
            S_LINK: begin
                // Link the chain end to the new block and advance
                mem_we    = 1'b1;
                mem_waddr = r_b;
                mem_wdata = ENTRY_W'(r_scan);
                n_b       = r_scan;
                n_k       = r_k - BLK_W'(1);
                if (k_last) begin
                    n_res = BLK_W'(r_scan);
                end else begin
                    mem_raddr = r_scan;
                end
            end
            S_WALK: begin
                if (e_end) begin
                    if (r_grow) begin
                        mem_raddr   = r_alloc_from;
                        n_scan      = r_alloc_from;
                        n_for_first = 1'b0;
                    end else begin
                        n_st = ST_NONE;
                    end
                end else if (e_out) begin
                    n_st = ST_NONE;
                end else begin
                    n_b = ADDR_W'(rdata);
                    n_k = r_k - BLK_W'(1);
                    if (k_last) begin
                        n_res = BLK_W'(rdata);
                    end else begin
                        mem_raddr = ADDR_W'(rdata);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_b          <= n_b;
        r_scan       <= n_scan;
        r_alloc_from <= n_alloc_from;
        r_k          <= n_k;
        r_grow       <= n_grow;
        r_for_first  <= n_for_first;
        r_count      <= n_count;
        r_res        <= n_res;
        r_fb         <= n_fb;
        r_st         <= n_st;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_result_block <= r_res;
            o_first_block  <= r_fb;
            o_freed_count  <= CNT_W'(r_count);
            o_status       <= r_st;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

FILE: hw/rtl/fcte_checker.sv
// Port-level checks for the chain table engine, bound to the top level.
module fcte_checker
    import fcte_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [BLK_W-1:0]   o_result_block,
    input logic [CNT_W-1:0]   o_freed_count,
    input logic [ST_W-1:0]    o_status
);

    // Hold a waiting result until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_result_block)
            && $stable(o_status) && $stable(o_freed_count))
        else $error("result changed while stalled");

    // Keep the input closed while the table is being cleared
    a_clear_closed: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("item accepted during clearing pass");

    // Take one item at a time
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second item accepted while busy");

    // Full table reports no block and frees nothing
    a_full_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_FULL |-> o_result_block == '0 && o_freed_count == '0)
        else $error("full status with a block or count");

    // No such block reports block zero
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_NONE |-> o_result_block == '0)
        else $error("none status with a block");

endmodule

bind fat_chain_table_engine_unit fcte_checker u_fcte_checker (.*);
